[design/wsdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants of the WebSocket receive deframer: parser
// phases, result kinds, header field constants and the result record.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	// Default width of the remaining payload length counter.
	localparam int LEN_WIDTH_DEF = 31;

	// Header field constants.
	localparam logic [7:0] HDR_FLAG_BIT = 8'h80;
	localparam logic [7:0] HDR_LEN_MASK = 8'h7f;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [7:0] OPCODE_MASK  = 8'h0f;

	// Last byte index (byte count minus one) of the mask key and of the ext16 and ext64 lengths.
	localparam logic [2:0] MASK_BYTES_LAST = 3'd3;
	localparam logic [2:0] EXT16_LAST      = 3'd1;
	localparam logic [2:0] EXT64_LAST      = 3'd7;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DATA  = 2'd0;
	localparam kind_t KIND_END   = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	typedef enum logic [5:0] {
		PH_HDR0  = 6'b000001,
		PH_HDR1  = 6'b000010,
		PH_EXT16 = 6'b000100,
		PH_EXT64 = 6'b001000,
		PH_MASK  = 6'b010000,
		PH_DATA  = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [3:0] opcode;
		logic       last_of_message;
	} result_t;

endpackage
`default_nettype wire

[design/wsdf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_if
// Valid/ready channels of the deframer: the received byte stream and the
// result stream.
// ----------------------------------------------------------------------------
interface wsdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload;
	logic [3:0] opcode;
	logic       last_of_message;

	modport source (output valid, output kind, output payload, output opcode,
		output last_of_message, input ready);
	modport sink (input valid, input kind, input payload, input opcode,
		input last_of_message, output ready);
endinterface
`default_nettype wire

[design/wsdf_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_core
// Input register and frame parser. Each registered byte advances the header
// state machine or unmasks one payload byte, until a protocol error stops it.
// ----------------------------------------------------------------------------
module wsdf_core #(
	parameter int LEN_WIDTH = wsdf_pkg::LEN_WIDTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           in_byte,
	input  wire                  res_free,
	output logic                 res_valid,
	output wsdf_pkg::result_t    res
);
	import wsdf_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 take;

	phase_t               phase_q, phase_d;
	logic [2:0]           hcount_q, hcount_d;
	logic                 final_q, final_d;
	logic [3:0]           msg_op_q, msg_op_d;
	logic                 in_msg_q, in_msg_d;
	logic [LEN_WIDTH-1:0] rem_q, rem_d;
	logic [31:0]          key_q, key_d;
	logic [1:0]           kidx_q, kidx_d;
	logic                 alive_q, alive_d;
	logic [7:0]           key_byte;
	logic [LEN_WIDTH-1:0] rem_shift;

	// The input register refills whenever its beat moves on to the parser.
	assign take     = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		unique case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign rem_shift = {rem_q[LEN_WIDTH-9:0], byte_s1};

	always_comb begin
		phase_d   = phase_q;
		hcount_d  = hcount_q;
		final_d   = final_q;
		msg_op_d  = msg_op_q;
		in_msg_d  = in_msg_q;
		rem_d     = rem_q;
		key_d     = key_q;
		kidx_d    = kidx_q;
		alive_d   = alive_q;
		res_valid = 1'b0;
		res.kind            = KIND_DATA;
		res.payload         = 8'd0;
		res.opcode          = msg_op_q;
		res.last_of_message = 1'b0;

		if (take && alive_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					final_d = byte_s1[7];
					if (!in_msg_q) begin
						msg_op_d = 4'(byte_s1 & OPCODE_MASK);
						in_msg_d = 1'b1;
					end
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					if ((byte_s1 & HDR_FLAG_BIT) == 8'd0) begin
						alive_d   = 1'b0;
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
					end else begin
						hcount_d = 3'd0;
						rem_d    = '0;
						if (byte_s1[6:0] == LEN_EXT16) begin
							phase_d = PH_EXT16;
						end else if (byte_s1[6:0] == LEN_EXT64) begin
							phase_d = PH_EXT64;
						end else begin
							rem_d   = LEN_WIDTH'(byte_s1 & HDR_LEN_MASK);
							phase_d = PH_MASK;
						end
					end
				end
				PH_EXT16: begin
					rem_d = rem_shift;
					if (hcount_q == EXT16_LAST) begin
						hcount_d = 3'd0;
						phase_d  = PH_MASK;
					end else begin
						hcount_d = hcount_q + 3'd1;
					end
				end
				PH_EXT64: begin
					// Shifting in one more byte would overflow the length counter.
					if (rem_q[LEN_WIDTH-1 -: 8] != 8'd0) begin
						alive_d   = 1'b0;
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
					end else begin
						rem_d = rem_shift;
						if (hcount_q == EXT64_LAST) begin
							hcount_d = 3'd0;
							phase_d  = PH_MASK;
						end else begin
							hcount_d = hcount_q + 3'd1;
						end
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], byte_s1};
					if (hcount_q == MASK_BYTES_LAST) begin
						hcount_d = 3'd0;
						kidx_d   = 2'd0;
						if (rem_q != '0) begin
							phase_d = PH_DATA;
						end else begin
							phase_d = PH_HDR0;
							if (final_q) begin
								in_msg_d            = 1'b0;
								res_valid           = 1'b1;
								res.kind            = KIND_END;
								res.last_of_message = 1'b1;
							end
						end
					end else begin
						hcount_d = hcount_q + 3'd1;
					end
				end
				PH_DATA: begin
					kidx_d      = kidx_q + 2'd1;
					rem_d       = rem_q - LEN_WIDTH'(1);
					res_valid   = 1'b1;
					res.kind    = KIND_DATA;
					res.payload = byte_s1 ^ key_byte;
					if (rem_q == LEN_WIDTH'(1)) begin
						phase_d = PH_HDR0;
						if (final_q) begin
							in_msg_d            = 1'b0;
							res.last_of_message = 1'b1;
						end
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			hcount_q <= 3'd0;
			final_q  <= 1'b0;
			msg_op_q <= 4'd0;
			in_msg_q <= 1'b0;
			rem_q    <= '0;
			key_q    <= 32'd0;
			kidx_q   <= 2'd0;
			alive_q  <= 1'b1;
		end else begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			final_q  <= final_d;
			msg_op_q <= msg_op_d;
			in_msg_q <= in_msg_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
			alive_q  <= alive_d;
		end
	end

endmodule
`default_nettype wire

[design/wsdf_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_out_reg
// Result register. Holds one result beat toward the sink and reports when it
// can take the next one.
// ----------------------------------------------------------------------------
module wsdf_out_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  res_valid,
	input  wsdf_pkg::result_t    res,
	output logic                 res_free,
	wsdf_out_if.source           out
);
	import wsdf_pkg::*;

	logic    out_valid_q;
	result_t out_q;

	// The register is free when empty or when its beat leaves this cycle.
	assign res_free = !out_valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out.valid           = out_valid_q;
	assign out.kind            = out_q.kind;
	assign out.payload         = out_q.payload;
	assign out.opcode          = out_q.opcode;
	assign out.last_of_message = out_q.last_of_message;

endmodule
`default_nettype wire

[design/websocket_frame_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side WebSocket frame parser: header decode, unmasking and message
// assembly over continuation frames.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat on rx and answers with at most
// one result beat on res: an unmasked payload byte, an end marker for an
// empty final frame, or a protocol error after which every byte is dropped
// until reset. It takes a byte in every cycle unless res back-pressures it;
// a byte passes the input register, is parsed combinationally and lands in
// the result register, which offers its result on res. Header, length and
// key bytes give no result but for an error or the end marker. Back-pressure
// from res stalls rx through the input register. LEN_WIDTH sets the payload
// length counter; a 64-bit length that does not fit in it raises the error.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
	parameter int LEN_WIDTH = wsdf_pkg::LEN_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	wsdf_in_if.sink     rx,
	wsdf_out_if.source  res
);
	import wsdf_pkg::*;

	logic    res_valid;
	result_t res_data;
	logic    res_free;

	wsdf_core #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.rx_byte),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res_data)
	);

	wsdf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res_data),
		.res_free  (res_free),
		.out       (res)
	);

endmodule
`default_nettype wire

[tb/sv/websocket_frame_deframer_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_tb
// Self-checking bench for the receive-side WebSocket deframer. A short table
// of hand-built frames runs first, then randomly built masked frames of all
// three length forms with random keys and payloads. Every accepted byte is
// run through a local frame parser, and each result beat is compared with the
// oldest predicted one. The run ends with a protocol error, either an unmasked
// frame or an oversized 64-bit length, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_tb;
	import wsdf_pkg::*;

	localparam int LEN_WIDTH     = LEN_WIDTH_DEF;
	localparam int RANDOM_BYTES  = 1500;
	localparam int HOLD_AT_BYTES = 600;
	localparam int QUIET_AT      = 1250;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int DEAD_BYTES    = 16;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		result_t    want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	wsdf_in_if  rx_ch ();
	wsdf_out_if res_ch ();

	websocket_frame_deframer_unit #(
		.LEN_WIDTH(LEN_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch.sink),
		.res(res_ch.source)
	);

	// Hand-built frames: a non-final frame with an all-ones key, a final
	// continuation with a 64-bit length, and an empty final frame.
	stim_row_t directed_rows [28] = '{
		'{8'h0F, 1'b0, '0}, '{8'h81, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_DATA, 8'hFF, 4'hF, 1'b0}},
		'{8'h80, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
		'{8'hA5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h5A, 1'b1, '{KIND_DATA, 8'hFF, 4'hF, 1'b1}},
		'{8'h81, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_END, 8'h00, 4'h1, 1'b1}}
	};

	// Parser state of the prediction.
	phase_t               ph;
	logic [2:0]           hdr_cnt;
	logic                 fin_q;
	logic [3:0]           msg_op;
	logic                 in_msg;
	logic [LEN_WIDTH-1:0] rem_len;
	logic [31:0]          key_q;
	logic [1:0]           key_idx;
	logic                 alive_q;

	result_t expected_results [$];
	int      error_count;
	int      bytes_sent;
	int      frames_sent;
	int      results_seen;
	int      stall_cycles;
	int      tx_idle_pct;
	bit      quiet_tail;
	bit      hold_request;
	bit      hold_done;

	always #5 clk = ~clk;

	// Returns 1 when the byte yields a result beat, and updates the parser.
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		logic [7:0] key_byte;
		logic       last;
		r = '0;
		if (!alive_q)
			return 1'b0;
		case (ph)
			PH_HDR0: begin
				fin_q = b[7];
				if (!in_msg) begin
					msg_op = b[3:0];
					in_msg = 1'b1;
				end
				ph = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				if (!b[7]) begin
					alive_q = 1'b0;
					r = '{KIND_ERROR, 8'h00, msg_op, 1'b0};
					return 1'b1;
				end
				rem_len = '0;
				hdr_cnt = '0;
				if (b[6:0] == LEN_EXT16)
					ph = PH_EXT16;
				else if (b[6:0] == LEN_EXT64)
					ph = PH_EXT64;
				else begin
					rem_len = LEN_WIDTH'(b[6:0]);
					ph = PH_MASK;
				end
				return 1'b0;
			end
			PH_EXT16: begin
				rem_len = {rem_len[LEN_WIDTH-9:0], b};
				if (hdr_cnt == EXT16_LAST) begin
					hdr_cnt = '0;
					ph = PH_MASK;
				end else
					hdr_cnt = hdr_cnt + 3'd1;
				return 1'b0;
			end
			PH_EXT64: begin
				// One more byte would push the length past the counter.
				if (rem_len[LEN_WIDTH-1:LEN_WIDTH-8] != 8'h00) begin
					alive_q = 1'b0;
					r = '{KIND_ERROR, 8'h00, msg_op, 1'b0};
					return 1'b1;
				end
				rem_len = {rem_len[LEN_WIDTH-9:0], b};
				if (hdr_cnt == EXT64_LAST) begin
					hdr_cnt = '0;
					ph = PH_MASK;
				end else
					hdr_cnt = hdr_cnt + 3'd1;
				return 1'b0;
			end
			PH_MASK: begin
				key_q = {key_q[23:0], b};
				if (hdr_cnt != MASK_BYTES_LAST) begin
					hdr_cnt = hdr_cnt + 3'd1;
					return 1'b0;
				end
				hdr_cnt = '0;
				key_idx = '0;
				if (rem_len != '0) begin
					ph = PH_DATA;
					return 1'b0;
				end
				ph = PH_HDR0;
				if (fin_q) begin
					in_msg = 1'b0;
					r = '{KIND_END, 8'h00, msg_op, 1'b1};
					return 1'b1;
				end
				return 1'b0;
			end
			PH_DATA: begin
				key_byte = key_q[31 - 8 * key_idx -: 8];
				key_idx = key_idx + 2'd1;
				rem_len = rem_len - 1'b1;
				last = 1'b0;
				if (rem_len == '0) begin
					ph = PH_HDR0;
					if (fin_q) begin
						last = 1'b1;
						in_msg = 1'b0;
					end
				end
				r = '{KIND_DATA, b ^ key_byte, msg_op, last};
				return 1'b1;
			end
			default: begin
				ph = PH_HDR0;
				return 1'b0;
			end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
		result_t predicted;
		bit      produced;
		bit      taken;
		if (!quiet_tail && tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
			rx_ch.valid = 1'b0;
			rx_ch.rx_byte = 8'($urandom);
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = b;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = rx_ch.ready;
			if (!taken)
				@(negedge clk);
		end
		produced = deframe_byte(b, predicted);
		if (typed)
			expected_results.push_back(want);
		else if (produced)
			expected_results.push_back(predicted);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_frame();
		logic [7:0]  hdr0;
		logic [31:0] key;
		int          len;
		int          pick;
		int          len_form;
		hdr0 = 8'($urandom);
		pick = $urandom_range(0, 99);
		len_form = 0;
		if (pick < 55)
			len = $urandom_range(0, 6);
		else if (pick < 80)
			len = $urandom_range(7, 40);
		else if (pick < 83)
			len = 125;
		else begin
			len_form = (pick < 94) ? 1 : 2;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 300)
				: $urandom_range(0, 40);
		end
		pick = $urandom_range(0, 9);
		key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);

		send_byte(hdr0, 1'b0, '0);
		if (len_form == 0)
			send_byte({1'b1, 7'(len)}, 1'b0, '0);
		else if (len_form == 1) begin
			send_byte({1'b1, LEN_EXT16}, 1'b0, '0);
			send_byte(8'(len >> 8), 1'b0, '0);
			send_byte(8'(len), 1'b0, '0);
		end else begin
			send_byte({1'b1, LEN_EXT64}, 1'b0, '0);
			for (int i = 7; i >= 0; i--)
				send_byte(8'(64'(len) >> (8 * i)), 1'b0, '0);
		end
		for (int i = 3; i >= 0; i--)
			send_byte(key[8 * i +: 8], 1'b0, '0);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), 1'b0, '0);
		frames_sent++;
	endtask

	task automatic report_result(input string what, input result_t want, input result_t got);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$write("%0t: %s: expected kind %0d payload %02h opcode %0h last %0b",
				$realtime, what, want.kind, want.payload, want.opcode,
				want.last_of_message);
			$display(", got kind %0d payload %02h opcode %0h last %0b",
				got.kind, got.payload, got.opcode, got.last_of_message);
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.kind, res_ch.payload, res_ch.opcode, res_ch.last_of_message};
			results_seen++;
			if (expected_results.size() == 0)
				report_result("result beat with nothing pending", '0, got);
			else begin
				want = expected_results.pop_front();
				if (got.kind != want.kind || got.payload != want.payload ||
						got.opcode != want.opcode ||
						got.last_of_message != want.last_of_message)
					report_result("result beat mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
			$display("websocket_frame_deframer_unit_tb: errors");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// Result side: random ready bursts, plus one long hold that lets the
	// block back up into its input.
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				res_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
				res_ch.ready = 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else
				res_ch.ready = 1'b1;
		end
	end

	initial begin
		bit          oversize_end;
		logic [7:0]  len_bytes [8];
		int          bad_pos;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		ph = PH_HDR0;
		hdr_cnt = '0;
		fin_q = 1'b0;
		msg_op = '0;
		in_msg = 1'b0;
		rem_len = '0;
		key_q = '0;
		key_idx = '0;
		alive_q = 1'b1;
		bytes_sent = 0;
		frames_sent = 0;
		tx_idle_pct = 0;
		quiet_tail = 1'b0;
		hold_request = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
		frames_sent = 3;

		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= HOLD_AT_BYTES)
				hold_request = 1'b1;
			if (bytes_sent >= QUIET_AT)
				quiet_tail = 1'b1;
			send_random_frame();
		end
		quiet_tail = 1'b1;

		// The error is fatal until reset, so it closes the run.
		oversize_end = 1'($urandom_range(0, 1));
		send_byte(8'($urandom), 1'b0, '0);
		if (oversize_end) begin
			send_byte({1'b1, LEN_EXT64}, 1'b0, '0);
			foreach (len_bytes[i])
				len_bytes[i] = 8'($urandom);
			for (int i = 0; i < 4; i++)
				len_bytes[i] = 8'h00;
			bad_pos = $urandom_range(0, 4);
			if (bad_pos == 4)
				len_bytes[4] = len_bytes[4] | HDR_FLAG_BIT;
			else
				len_bytes[bad_pos] = 8'($urandom_range(1, 255));
			foreach (len_bytes[i])
				send_byte(len_bytes[i], 1'b0, '0);
		end else
			send_byte(8'($urandom_range(0, 127)), 1'b0, '0);
		frames_sent++;
		for (int i = 0; i < DEAD_BYTES; i++)
			send_byte(8'($urandom), 1'b0, '0);
		rx_ch.valid = 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d frames; %0d result beats checked.",
			bytes_sent, frames_sent, results_seen);
		$display("Closing protocol error: %s, then %0d dropped bytes.",
			oversize_end ? "oversized 64-bit length" : "unmasked frame", DEAD_BYTES);
		if (error_count == 0)
			$display("websocket_frame_deframer_unit_tb: clean");
		else
			$display("websocket_frame_deframer_unit_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
